>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge.
`define CHK_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define CHK_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> rtl/ilb_pkg.sv
// ---------------------------------------------------------------------------
// Indexed list buffer package
// Command and status codes, cell control bundle and default sizes.
// ---------------------------------------------------------------------------
package ilb_pkg;

    localparam int CAPACITY_DEF      = 64;
    localparam int ELEMENT_WIDTH_DEF = 32;
    localparam int IDX_W             = 7;
    localparam int VAL_W             = 32;
    localparam int CNT_W             = 7;
    localparam int MODE_W            = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH     = 3'd0,
        MODE_POP      = 3'd1,
        MODE_INSERT   = 3'd2,
        MODE_REMOVE   = 3'd3,
        MODE_READ_IDX = 3'd4,
        MODE_READ_END = 3'd5,
        MODE_CLEAR    = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic write_en;
        logic rd_en;
        logic tap_load;
    } t_cell_ctl;

endpackage

>>> rtl/ilb_cell.sv
// ---------------------------------------------------------------------------
// Indexed list buffer cell
// Holds one list entry; loads from its lower or upper neighbour, or the
// broadcast word, and presents its entry on a registered read tap.
// ---------------------------------------------------------------------------
module ilb_cell
    import ilb_pkg::*;
#(
    parameter int POS = 0,
    parameter int CW  = IDX_W,
    parameter int EW  = ELEMENT_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctl     i_ctl,
    input  logic [CW-1:0] i_pos,
    input  logic [CW-1:0] i_rd_pos,
    input  logic [EW-1:0] i_value,
    input  logic [EW-1:0] i_below,
    input  logic [EW-1:0] i_above,
    output logic [EW-1:0] o_data,
    output logic [EW-1:0] o_tap
);

    localparam logic [CW-1:0] MyPos = CW'(POS);

    logic [EW-1:0] r_data;
    logic [EW-1:0] r_tap;
    logic          r_tap_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.write_en && (i_pos == MyPos)) begin
            r_data <= i_value;
        end else if (i_ctl.shift_up && (MyPos > i_pos)) begin
            r_data <= i_below;
        end else if (i_ctl.shift_down && (MyPos >= i_pos)) begin
            r_data <= i_above;
        end
        if (i_ctl.tap_load) begin
            r_tap <= r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_hit <= 1'b0;
        end else if (i_ctl.tap_load) begin
            r_tap_hit <= i_ctl.rd_en && (i_rd_pos == MyPos);
        end
    end

    assign o_data = r_data;
    assign o_tap  = r_tap_hit ? r_tap : '0;

endmodule

>>> rtl/indexed_list_buffer.sv
// ---------------------------------------------------------------------------
// Indexed list buffer
// Ordered list of up to CAPACITY words held in a row of cells that shift
// together on insert and remove; one command in, one result out.
// ---------------------------------------------------------------------------
//  Channel  Direction  Payload
//  s        in         tuser: mode; tdata: index, value
//  m        out        tuser: status; tdata: read_value, entry_count
//
//  An accepted command's result passes the tap stage, then the output register.
//  One command per cycle is sustained while the result side keeps up; the
//  cell row updates all affected entries in the accepting cycle.
//  The read path runs through each cell's tap register and one OR stage.
//  Reset empties the list at once; no clearing pass is needed.
//  A stall on the result side holds the tap stage and then the input.
module indexed_list_buffer
    import ilb_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // index[6:0], value[38:7], zero pad
    input  logic [2:0]  i_s_tuser,  // mode[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,  // read_value[31:0], entry_count[38:32], zero pad
    output logic [1:0]  o_m_tuser   // status[1:0]
);

    `include "assert_macros.svh"

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int CW = (IW > IDX_W) ? IW : IDX_W;
    localparam int XW = (ELEMENT_WIDTH > VAL_W) ? ELEMENT_WIDTH : VAL_W;
    localparam logic [CW-1:0] CapX = CW'(CAPACITY);

    logic [IW-1:0]            r_count;
    logic [IW-1:0]            n_count;
    logic                     r_s1_valid;
    logic [IW-1:0]            r_s1_count;
    t_status                  r_s1_status;
    logic                     r_out_valid;
    logic [VAL_W-1:0]         r_out_value;
    logic [CNT_W-1:0]         r_out_count;
    t_status                  r_out_status;

    logic                     w_accept;
    logic                     w_s1_adv;
    t_cell_ctl                w_ctl;
    t_status                  w_status;
    logic [CW-1:0]            w_pos;
    logic [CW-1:0]            w_rd_pos;
    logic [CW-1:0]            w_cnt_x;
    logic [CW-1:0]            w_idx_x;
    logic [XW-1:0]            w_value_x;
    logic [ELEMENT_WIDTH-1:0] w_word;
    logic [ELEMENT_WIDTH-1:0] w_data  [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] w_tap   [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] w_below [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] w_above [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] w_rd_or;
    logic [XW-1:0]            w_rd_x;

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || w_s1_adv;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_cnt_x   = CW'(r_count);
    assign w_idx_x   = CW'(i_s_tdata[6:0]);
    assign w_value_x = XW'(i_s_tdata[38:7]);
    assign w_word    = w_value_x[ELEMENT_WIDTH-1:0];

    always_comb begin
        w_ctl    = '0;
        w_status = ST_OK;
        w_pos    = w_idx_x;
        w_rd_pos = w_idx_x;
        n_count  = r_count;
        unique case (t_mode'(i_s_tuser))
            MODE_PUSH: begin
                if (w_cnt_x >= CapX) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.write_en = 1'b1;
                    w_pos          = w_cnt_x;
                    n_count        = r_count + IW'(1);
                end
            end
            MODE_POP: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_count = r_count - IW'(1);
                end
            end
            MODE_INSERT: begin
                if (w_idx_x > w_cnt_x) begin
                    w_status = ST_BAD_INDEX;
                end else if (w_cnt_x >= CapX) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.write_en = 1'b1;
                    w_ctl.shift_up = 1'b1;
                    n_count        = r_count + IW'(1);
                end
            end
            MODE_REMOVE: begin
                if (w_idx_x >= w_cnt_x) begin
                    w_status = ST_BAD_INDEX;
                end else begin
                    w_ctl.shift_down = 1'b1;
                    n_count          = r_count - IW'(1);
                end
            end
            MODE_READ_IDX: begin
                if (w_idx_x >= w_cnt_x) begin
                    w_status = ST_BAD_INDEX;
                end else begin
                    w_ctl.rd_en = 1'b1;
                end
            end
            MODE_READ_END: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctl.rd_en = 1'b1;
                    w_rd_pos    = w_cnt_x - CW'(1);
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        w_ctl.tap_load = 1'b1;
        if (!w_accept) begin
            w_ctl   = '0;
            n_count = r_count;
        end
    end

    for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
        if (c == 0) begin : g_lo
            assign w_below[c] = '0;
        end else begin : g_lo
            assign w_below[c] = w_data[c-1];
        end
        if (c == CAPACITY - 1) begin : g_hi
            assign w_above[c] = '0;
        end else begin : g_hi
            assign w_above[c] = w_data[c+1];
        end

        ilb_cell #(
            .POS (c),
            .CW  (CW),
            .EW  (ELEMENT_WIDTH)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_pos    (w_pos),
            .i_rd_pos (w_rd_pos),
            .i_value  (w_word),
            .i_below  (w_below[c]),
            .i_above  (w_above[c]),
            .o_data   (w_data[c]),
            .o_tap    (w_tap[c])
        );
    end

    always_comb begin
        w_rd_or = '0;
        for (int c = 0; c < CAPACITY; c++) begin
            w_rd_or = w_rd_or | w_tap[c];
        end
    end

    assign w_rd_x = XW'(w_rd_or);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_count  <= n_count;
            r_s1_status <= w_status;
        end
        if (w_s1_adv) begin
            r_out_value  <= w_rd_x[VAL_W-1:0];
            r_out_count  <= CNT_W'(r_s1_count);
            r_out_status <= r_s1_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_count, r_out_value};
    assign o_m_tuser  = r_out_status;

    `CHK_ALWAYS(a_count_range, r_count <= IW'(CAPACITY), "entry count above capacity")
    `CHK_NEXT(a_s1_load, w_accept, r_s1_valid, "accepted command missing from tap stage")
    `CHK_ALWAYS(a_full_count, !(r_s1_valid && (r_s1_status == ST_FULL)) || (r_s1_count == IW'(CAPACITY)), "full status without a full list")
    `CHK_NEXT(a_out_load, w_s1_adv, o_m_tvalid, "tap stage advanced without a result")

endmodule

>>> dv/ilb_result_checker.sv
// ---------------------------------------------------------------------------
// Indexed list buffer result checker
// Watches both stream channels of the list buffer. Every accepted command
// beat is run through a behavioural copy of the list to give the expected
// result. Every accepted result beat is compared field by field with the
// oldest expected result. Mismatches and results that arrive with nothing
// expected are counted as failures and handed to the testbench top.
// ---------------------------------------------------------------------------
module ilb_result_checker
    import ilb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,  // index[6:0], value[38:7], zero pad
    input  logic [2:0]  i_s_tuser,  // mode[2:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,  // read_value[31:0], entry_count[38:32], zero pad
    input  logic [1:0]  i_m_tuser,  // status[1:0]
    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_checked,
    output int          o_full_seen,
    output int          o_bad_index_seen,
    output int          o_empty_seen
);

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [CNT_W-1:0] entry_count;
        t_status          status;
    } list_result_t;

    logic [VAL_W-1:0] list_words [CAPACITY_DEF];
    int               list_len;
    list_result_t     expected_results [$];

    int fail_count;
    int checked;
    int full_seen;
    int bad_index_seen;
    int empty_seen;

    function automatic list_result_t apply_list_cmd(input logic [MODE_W-1:0] mode,
                                                    input int idx,
                                                    input logic [VAL_W-1:0] word);
        list_result_t res;
        int           i;
        res.read_value = '0;
        res.status     = ST_OK;
        case (mode)
            MODE_PUSH: begin
                if (list_len >= CAPACITY_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[list_len] = word;
                    list_len++;
                end
            end
            MODE_POP: begin
                if (list_len == 0) res.status = ST_EMPTY;
                else list_len--;
            end
            MODE_INSERT: begin
                if (idx > list_len) begin
                    res.status = ST_BAD_INDEX;
                end else if (list_len >= CAPACITY_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = list_len; i > idx; i--) list_words[i] = list_words[i-1];
                    list_words[idx] = word;
                    list_len++;
                end
            end
            MODE_REMOVE: begin
                if (idx >= list_len) begin
                    res.status = ST_BAD_INDEX;
                end else begin
                    for (i = idx; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            MODE_READ_IDX: begin
                if (idx >= list_len) res.status = ST_BAD_INDEX;
                else res.read_value = list_words[idx];
            end
            MODE_READ_END: begin
                if (list_len == 0) res.status = ST_EMPTY;
                else res.read_value = list_words[list_len-1];
            end
            MODE_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        res.entry_count = CNT_W'(list_len);
        return res;
    endfunction

    always @(posedge i_clk) begin
        list_result_t got;
        list_result_t want;
        if (!i_rst_n) begin
            list_len = 0;
            expected_results.delete();
            fail_count     = 0;
            checked        = 0;
            full_seen      = 0;
            bad_index_seen = 0;
            empty_seen     = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(apply_list_cmd(i_s_tuser, int'(i_s_tdata[6:0]),
                                                          i_s_tdata[38:7]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.read_value  = i_m_tdata[31:0];
                got.entry_count = i_m_tdata[38:32];
                got.status      = t_status'(i_m_tuser);
                if (expected_results.size() == 0) begin
                    $error("Result beat with nothing expected: read_value %0d, count %0d, %s",
                           $signed(got.read_value), got.entry_count, got.status.name());
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    case (want.status)
                        ST_FULL:      full_seen++;
                        ST_BAD_INDEX: bad_index_seen++;
                        ST_EMPTY:     empty_seen++;
                        default: begin
                        end
                    endcase
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.read_value), $signed(got.read_value));
                        fail_count++;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, got.entry_count);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %s, got %0d",
                               want.status.name(), i_m_tuser);
                        fail_count++;
                    end
                end
            end
        end
        o_fail_count     <= fail_count;
        o_outstanding    <= expected_results.size();
        o_checked        <= checked;
        o_full_seen      <= full_seen;
        o_bad_index_seen <= bad_index_seen;
        o_empty_seen     <= empty_seen;
    end

endmodule

>>> dv/tb_indexed_list_buffer.sv
// ---------------------------------------------------------------------------
// Indexed list buffer testbench
// Drives list commands into the buffer over its input stream and accepts
// results on its output stream, with random gaps on both sides and one long
// hold-off on the result side. A short directed sequence covers the empty,
// bad index and extreme value cases; random command runs that drift towards
// growth, shrinkage or balance then reach the full list repeatedly.
// ---------------------------------------------------------------------------
module tb_indexed_list_buffer;
    import ilb_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam int N_RANDOM    = 2000;
    localparam int HOLD_CYCLES = 300;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata  = '0;
    logic [2:0]  i_s_tuser  = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    int fail_count;
    int outstanding;
    int checked;
    int full_seen;
    int bad_index_seen;
    int empty_seen;

    int tx_idle_pct = 19;
    int rx_idle_pct = 54;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;
    int hold_left   = 0;

    int shadow_len  = 0;
    int n_directed  = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    indexed_list_buffer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    ilb_result_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (i_s_tvalid),
        .i_s_tready       (o_s_tready),
        .i_s_tdata        (i_s_tdata),
        .i_s_tuser        (i_s_tuser),
        .i_m_tvalid       (o_m_tvalid),
        .i_m_tready       (i_m_tready),
        .i_m_tdata        (o_m_tdata),
        .i_m_tuser        (o_m_tuser),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding),
        .o_checked        (checked),
        .o_full_seen      (full_seen),
        .o_bad_index_seen (bad_index_seen),
        .o_empty_seen     (empty_seen)
    );

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left  <= HOLD_CYCLES;
            hold_done  <= 1'b1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic int len_after(input logic [MODE_W-1:0] mode, input int idx,
                                     input int len);
        case (mode)
            MODE_PUSH:   return (len < CAPACITY_DEF) ? len + 1 : len;
            MODE_POP:    return (len > 0) ? len - 1 : len;
            MODE_INSERT: return (idx <= len && len < CAPACITY_DEF) ? len + 1 : len;
            MODE_REMOVE: return (idx < len) ? len - 1 : len;
            MODE_CLEAR:  return 0;
            default:     return len;
        endcase
    endfunction

    task automatic send_cmd(input logic [MODE_W-1:0] mode, input int idx,
                            input logic [VAL_W-1:0] word);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {1'b0, word, idx[6:0]};
        shadow_len = len_after(mode, idx, shadow_len);
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_word();
        case ($urandom_range(24))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_cmd(input int drift);
        int                th [7];
        int                r;
        int                p;
        int                idx;
        logic [MODE_W-1:0] mode;
        case (drift)
            0:       th = '{400, 750, 800, 850, 940, 990, 997};
            1:       th = '{100, 200, 450, 700, 850, 950, 990};
            default: th = '{250, 450, 600, 750, 880, 960, 995};
        endcase
        r = $urandom_range(999);
        if (r < th[0])      mode = MODE_PUSH;
        else if (r < th[1]) mode = MODE_INSERT;
        else if (r < th[2]) mode = MODE_POP;
        else if (r < th[3]) mode = MODE_REMOVE;
        else if (r < th[4]) mode = MODE_READ_IDX;
        else if (r < th[5]) mode = MODE_READ_END;
        else if (r < th[6]) mode = MODE_CLEAR;
        else                mode = MODE_UNUSED;
        p = $urandom_range(99);
        if (p < 70) begin
            if (mode == MODE_INSERT) idx = $urandom_range(shadow_len, 0);
            else idx = (shadow_len > 0) ? $urandom_range(shadow_len - 1, 0) : 0;
        end else if (p < 85) begin
            idx = shadow_len;
        end else begin
            idx = $urandom_range(CAPACITY_DEF, 0);
        end
        send_cmd(mode, idx, pick_word());
    endtask

    initial begin
        int drift;
        int k;
        drift = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_cmd(MODE_POP,      0,  32'h0);
        send_cmd(MODE_READ_END, 0,  32'h0);
        send_cmd(MODE_REMOVE,   0,  32'h0);
        send_cmd(MODE_READ_IDX, 0,  32'h0);
        send_cmd(MODE_INSERT,   1,  32'h1234_5678);
        send_cmd(MODE_UNUSED,   5,  32'hDEAD_BEEF);
        send_cmd(MODE_PUSH,     0,  32'h7FFF_FFFF);
        send_cmd(MODE_PUSH,     64, 32'h8000_0000);
        send_cmd(MODE_INSERT,   0,  32'h0000_0000);
        send_cmd(MODE_INSERT,   3,  32'hFFFF_FFFF);
        send_cmd(MODE_READ_IDX, 0,  32'h0);
        send_cmd(MODE_READ_IDX, 3,  32'h0);
        send_cmd(MODE_READ_IDX, 4,  32'h0);
        send_cmd(MODE_READ_IDX, 64, 32'h0);
        send_cmd(MODE_READ_END, 0,  32'h0);
        send_cmd(MODE_REMOVE,   1,  32'h0);
        send_cmd(MODE_REMOVE,   2,  32'h0);
        send_cmd(MODE_REMOVE,   64, 32'h0);
        send_cmd(MODE_INSERT,   1,  32'h5555_AAAA);
        send_cmd(MODE_READ_IDX, 1,  32'h0);
        send_cmd(MODE_POP,      0,  32'h0);
        send_cmd(MODE_CLEAR,    0,  32'h0);
        send_cmd(MODE_READ_END, 0,  32'h0);
        n_directed = 23;

        for (k = 0; k < N_RANDOM; k++) begin
            if (k % 150 == 0) drift = $urandom_range(2);
            if (k == N_RANDOM / 3) begin
                tx_idle_pct = 54;
                rx_idle_pct <= 19;
            end else if (k == 2 * N_RANDOM / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
                hold_req    <= 1'b1;
            end
            random_cmd(drift);
        end
        i_s_tvalid <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d commands (%0d directed, %0d random) and checked %0d results.",
                 n_directed + N_RANDOM, n_directed, N_RANDOM, checked);
        $display("Results with full status: %0d, bad index: %0d, empty: %0d.",
                 full_seen, bad_index_seen, empty_seen);
        if (outstanding != 0) $error("%0d expected results never arrived", outstanding);
        if (fail_count == 0 && outstanding == 0) begin
            $display("indexed_list_buffer regression: pass");
        end else begin
            $display("indexed_list_buffer regression: fail");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("indexed_list_buffer regression: fail");
        $finish;
    end

endmodule
